### rtl/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types and constants of the component timing monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ctm_pkg;

    localparam int NUM_COMPONENTS_DEF = 13;
    localparam int COMP_W             = 4;
    localparam int TIME_W             = 32;
    localparam int CFG_IDX_W          = 1;

    localparam logic [TIME_W-1:0] SLOW_THRESHOLD_RST = 32'd50000;
    localparam logic [TIME_W-1:0] ALERT_INTERVAL_RST = 32'd10000;
    localparam logic [TIME_W-1:0] COUNT_MAX          = '1;

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } ctm_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_THRESHOLD = 1'b0,
        REG_ALERT_INTERVAL = 1'b1
    } ctm_reg_t;

    // One table entry, stored as a single memory word.
    typedef struct packed {
        logic [TIME_W-1:0] latest;
        logic [TIME_W-1:0] peak;
        logic [TIME_W-1:0] slow_count;
        logic [TIME_W-1:0] slow_dur;
        logic [TIME_W-1:0] slow_time;
        logic [TIME_W-1:0] alert_time;
    } ctm_entry_t;

    localparam int ENTRY_W = $bits(ctm_entry_t);

    typedef struct packed {
        logic              should_alert;
        logic [TIME_W-1:0] run_us;
        logic [TIME_W-1:0] latest_us;
        logic [TIME_W-1:0] peak_us;
        logic [TIME_W-1:0] slow_total;
        logic [TIME_W-1:0] latest_slow_us;
        logic [TIME_W-1:0] slow_age_ms;
    } ctm_result_t;

endpackage

`default_nettype wire

### rtl/ctm_if.sv
// ----------------------------------------------------------------------------
// ctm_if
// Command and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ctm_cmd_if
    import ctm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [0:0]        opcode;
    logic [COMP_W-1:0] component;
    logic [TIME_W-1:0] started_us;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, opcode, component, started_us, now_us, now_ms,
                    input ready);
    modport sink   (input valid, opcode, component, started_us, now_us, now_ms,
                    output ready);
endinterface

interface ctm_rsp_if
    import ctm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              bad_component;
    logic              should_alert;
    logic [TIME_W-1:0] run_us;
    logic [TIME_W-1:0] latest_us;
    logic [TIME_W-1:0] peak_us;
    logic [TIME_W-1:0] slow_total;
    logic [TIME_W-1:0] latest_slow_us;
    logic [TIME_W-1:0] slow_age_ms;

    modport source (output valid, bad_component, should_alert, run_us, latest_us,
                    peak_us, slow_total, latest_slow_us, slow_age_ms,
                    input ready);
    modport sink   (input valid, bad_component, should_alert, run_us, latest_us,
                    peak_us, slow_total, latest_slow_us, slow_age_ms,
                    output ready);
endinterface

`default_nettype wire

### rtl/ctm_ram.sv
// ----------------------------------------------------------------------------
// ctm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read during write to the same address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ctm_update.sv
// ----------------------------------------------------------------------------
// ctm_update
// Entry update: duration, peak, slow counting, alert pacing and slow age.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_update
    import ctm_pkg::*;
(
    input  wire logic [0:0]        opcode,
    input  wire ctm_entry_t        entry_cur,
    input  wire logic [TIME_W-1:0] started_us,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic [TIME_W-1:0] slow_threshold,
    input  wire logic [TIME_W-1:0] alert_interval,
    output ctm_entry_t             entry_new,
    output ctm_result_t            result
);

    logic [TIME_W-1:0] run;
    logic [TIME_W-1:0] since_alert;
    logic              is_rec;
    logic              slow;
    logic              alert;

    always_comb
    begin
        is_rec      = (ctm_op_t'(opcode) == OP_RECORD);
        run         = now_us - started_us;
        since_alert = now_ms - entry_cur.alert_time;
        slow        = is_rec && (run > slow_threshold);
        alert       = slow && ((entry_cur.alert_time == '0) ||
                               (since_alert >= alert_interval));

        entry_new = entry_cur;
        if (is_rec)
        begin
            entry_new.latest = run;
            if (run > entry_cur.peak)
            begin
                entry_new.peak = run;
            end
        end
        if (slow)
        begin
            if (entry_cur.slow_count != COUNT_MAX)
            begin
                entry_new.slow_count = entry_cur.slow_count + TIME_W'(1);
            end
            entry_new.slow_dur  = run;
            entry_new.slow_time = now_ms;
        end
        if (alert)
        begin
            entry_new.alert_time = now_ms;
        end

        result.should_alert   = alert;
        result.run_us         = is_rec ? run : '0;
        result.latest_us      = entry_new.latest;
        result.peak_us        = entry_new.peak;
        result.slow_total     = entry_new.slow_count;
        result.latest_slow_us = entry_new.slow_dur;
        // A slow record leaves the slow time at now_ms: age is zero.
        if (slow || (entry_cur.slow_time == '0))
        begin
            result.slow_age_ms = '0;
        end
        else
        begin
            result.slow_age_ms = now_ms - entry_cur.slow_time;
        end
    end

endmodule

`default_nettype wire

### rtl/component_timing_monitor.sv
// ----------------------------------------------------------------------------
// component_timing_monitor
// Per-component run timing statistics with slow counting and paced alerts.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per transfer: record a finished run (duration
//   now_us - started_us) or read an entry. rsp returns exactly one result per
//   command, in order. cfg_wr_en/cfg_index/cfg_wdata write the slow threshold
//   and the alert interval; write them only while no command is in flight.
// Pipeline: a command passes through stage 1 (table read), then the
//   response register (update and write-back), which drives rsp.
// Throughput: one command per cycle unless rsp stalls. The entry table
//   lives in one RAM with one read and one write port; a command to the
//   entry being written in the same cycle takes the new entry from a
//   forwarding register.
// Reset: clears a valid bit per entry, so every entry reads as all zero right
//   away; no clearing pass, commands are accepted as soon as reset ends.
// Stall: if rsp is not taken, the response register holds, the stage behind
//   it holds its command and cmd.ready drops until rsp moves again.
// Out-of-range components return bad_component with all other fields zero
//   and leave the table untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module component_timing_monitor
    import ctm_pkg::*;
#(
    parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_wdata,
    ctm_cmd_if.sink                   cmd,
    ctm_rsp_if.source                 rsp
);

    localparam int IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    // Configuration registers
    logic [TIME_W-1:0] slow_threshold_reg;
    logic [TIME_W-1:0] alert_interval_reg;

    // Entry valid bits: cleared at reset, set on first write-back
    logic [NUM_COMPONENTS-1:0] vld_reg;
    logic [NUM_COMPONENTS-1:0] vld_next;

    // Stage 1: command waiting on table read data
    logic              s1_valid_reg;
    logic [0:0]        s1_op_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_bad_reg;
    logic [TIME_W-1:0] s1_started_reg;
    logic [TIME_W-1:0] s1_now_us_reg;
    logic [TIME_W-1:0] s1_now_ms_reg;
    logic              s1_vld_reg;
    logic              s1_fwd_reg;
    ctm_entry_t        fwd_entry_reg;

    // Response register
    logic        out_valid_reg;
    logic        out_bad_reg;
    ctm_result_t out_res_reg;

    logic        cmd_fire;
    logic        s1_fire;
    logic        cmd_bad;
    logic [IDX_W-1:0] cmd_idx;
    logic        ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    ctm_entry_t  entry_cur;
    ctm_entry_t  entry_new;
    ctm_result_t upd_res;
    logic        fwd_hit;

    assign cmd_bad  = ({1'b0, cmd.component} >= (COMP_W + 1)'(NUM_COMPONENTS));
    // Bad commands read entry 0; their data is discarded.
    assign cmd_idx  = cmd_bad ? '0 : IDX_W'(cmd.component);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;
    assign cmd_fire = cmd.valid && cmd.ready;
    assign ram_we   = s1_fire && !s1_bad_reg && (ctm_op_t'(s1_op_reg) == OP_RECORD);
    assign fwd_hit  = ram_we && !cmd_bad && (s1_idx_reg == cmd_idx);

    // Current entry: forwarded write, else RAM word, else reset value
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            entry_cur = fwd_entry_reg;
        end
        else if (s1_vld_reg)
        begin
            entry_cur = ctm_entry_t'(ram_rdata);
        end
        else
        begin
            entry_cur = '0;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[s1_idx_reg] = 1'b1;
        end
    end

    ctm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_COMPONENTS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (ENTRY_W'(entry_new)),
        .re    (cmd_fire),
        .raddr (cmd_idx),
        .rdata (ram_rdata)
    );

    ctm_update u_update (
        .opcode         (s1_op_reg),
        .entry_cur      (entry_cur),
        .started_us     (s1_started_reg),
        .now_us         (s1_now_us_reg),
        .now_ms         (s1_now_ms_reg),
        .slow_threshold (slow_threshold_reg),
        .alert_interval (alert_interval_reg),
        .entry_new      (entry_new),
        .result         (upd_res)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_threshold_reg <= SLOW_THRESHOLD_RST;
            alert_interval_reg <= ALERT_INTERVAL_RST;
            vld_reg            <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (ctm_reg_t'(cfg_index))
                    REG_SLOW_THRESHOLD: slow_threshold_reg <= cfg_wdata;
                    REG_ALERT_INTERVAL: alert_interval_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
            vld_reg <= vld_next;
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_op_reg      <= cmd.opcode;
            s1_idx_reg     <= cmd_idx;
            s1_bad_reg     <= cmd_bad;
            s1_started_reg <= cmd.started_us;
            s1_now_us_reg  <= cmd.now_us;
            s1_now_ms_reg  <= cmd.now_ms;
            s1_vld_reg     <= vld_reg[cmd_idx];
            s1_fwd_reg     <= fwd_hit;
            fwd_entry_reg  <= entry_new;
        end
        if (s1_fire)
        begin
            out_bad_reg <= s1_bad_reg;
            out_res_reg <= s1_bad_reg ? '0 : upd_res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.bad_component  = out_bad_reg;
    assign rsp.should_alert   = out_res_reg.should_alert;
    assign rsp.run_us         = out_res_reg.run_us;
    assign rsp.latest_us      = out_res_reg.latest_us;
    assign rsp.peak_us        = out_res_reg.peak_us;
    assign rsp.slow_total     = out_res_reg.slow_total;
    assign rsp.latest_slow_us = out_res_reg.latest_slow_us;
    assign rsp.slow_age_ms    = out_res_reg.slow_age_ms;

    // A stalled stage 1 keeps its command.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg)
        else $error("stage 1 command lost during stall");

    // Out-of-range commands never touch the table.
    a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s1_bad_reg)
        else $error("table write for bad component");

    // A command to the entry just written must take the forwarded word.
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && ram_we && !cmd_bad && (s1_idx_reg == cmd_idx)) |=> s1_fwd_reg)
        else $error("missed forwarding of same-entry write");

    // A bad response carries no alert and no duration.
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (!out_res_reg.should_alert &&
                                            (out_res_reg.run_us == '0)))
        else $error("bad component response has nonzero fields");

endmodule

`default_nettype wire

### dv/tb_component_timing_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_component_timing_monitor
// Self-checking bench for the component timing monitor. A directed table
// covers reset contents, out-of-range components, the slow threshold edge,
// alert pacing, timestamp wrap and the slow-at-time-zero case. A random
// part follows under several register settings. Every response is compared
// field by field against a behavioral model of the statistics table, or a
// typed-in outcome for fixed rows, with random gaps on the command side and
// random back-pressure on the response side.
// ----------------------------------------------------------------------------
module tb_component_timing_monitor;
    import ctm_pkg::*;

    localparam int NCOMP        = NUM_COMPONENTS_DEF;
    localparam int RANDOM_ITEMS = 1330;
    localparam int N_PHASES     = 5;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 64;    // long response hold-off, fills the pipe
    localparam int DRAIN_CYCLES = 6;     // idle wait after the final drain
    localparam int MAX_REPORTS  = 40;

    // Expected or observed response: the package result plus the error flag.
    typedef struct packed {
        logic        bad;
        ctm_result_t res;
    } timing_outcome_t;

    // One command; 'fixed' marks table rows whose outcome is typed in.
    typedef struct {
        ctm_op_t           op;
        logic [COMP_W-1:0] comp;
        logic [TIME_W-1:0] started;
        logic [TIME_W-1:0] end_us;
        logic [TIME_W-1:0] now_ms;
        bit                fixed;
        timing_outcome_t   outcome;
    } timing_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    ctm_reg_t             cfg_index;
    logic [TIME_W-1:0]    cfg_wdata;

    ctm_cmd_if cmd_ch ();
    ctm_rsp_if rsp_ch ();

    component_timing_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral copy of the statistics table and its two registers
    // ------------------------------------------------------------------
    ctm_entry_t        model_tab [NCOMP];
    logic [TIME_W-1:0] model_thr;
    logic [TIME_W-1:0] model_ivl;

    timing_outcome_t   pending_outcomes [$];   // one per accepted command, in order
    timing_cmd_t       cur_cmd;                // command currently on the bus
    timing_cmd_t       directed_rows [$];

    int  error_count   = 0;
    int  burst_left    = 0;
    bit  hold_req      = 1'b0;
    logic [TIME_W-1:0] ms_clock = '0;

    // coverage-ish tallies for the summary
    int  n_record = 0, n_read = 0, n_bad = 0, n_alert = 0, n_settings = 0;
    int  n_cmd_stall = 0;

    // Table update for one command; returns the response it must produce.
    function automatic timing_outcome_t predict_timing(ctm_op_t op,
                                                       logic [COMP_W-1:0] comp,
                                                       logic [TIME_W-1:0] started,
                                                       logic [TIME_W-1:0] end_us,
                                                       logic [TIME_W-1:0] now_ms);
        timing_outcome_t   o;
        ctm_entry_t        e;
        logic [TIME_W-1:0] dur;
        o = '0;
        if (comp >= NCOMP)
        begin
            o.bad = 1'b1;   // nothing touched, all other fields zero
            return o;
        end
        e = model_tab[comp];
        if (op == OP_RECORD)
        begin
            dur = end_us - started;
            e.latest = dur;
            if (dur > e.peak)
                e.peak = dur;
            if (dur > model_thr)
            begin
                if (e.slow_count != COUNT_MAX)
                    e.slow_count = e.slow_count + 1'b1;
                e.slow_dur  = dur;
                e.slow_time = now_ms;
                // alert time of zero means "never alerted"
                if (e.alert_time == '0 || (now_ms - e.alert_time) >= model_ivl)
                begin
                    e.alert_time       = now_ms;
                    o.res.should_alert = 1'b1;
                end
            end
            o.res.run_us = dur;
            model_tab[comp] = e;
        end
        o.res.latest_us      = e.latest;
        o.res.peak_us        = e.peak;
        o.res.slow_total     = e.slow_count;
        o.res.latest_slow_us = e.slow_dur;
        // age taken after the update; slow time zero reads as never slow
        o.res.slow_age_ms    = (e.slow_time != '0) ? now_ms - e.slow_time : '0;
        return o;
    endfunction

    function automatic timing_outcome_t outcome(bit bad, bit alert,
                                                logic [TIME_W-1:0] run, latest, peak,
                                                logic [TIME_W-1:0] total, sdur, age);
        timing_outcome_t o;
        o.bad                = bad;
        o.res.should_alert   = alert;
        o.res.run_us         = run;
        o.res.latest_us      = latest;
        o.res.peak_us        = peak;
        o.res.slow_total     = total;
        o.res.latest_slow_us = sdur;
        o.res.slow_age_ms    = age;
        return o;
    endfunction

    function automatic timing_cmd_t row(ctm_op_t op, logic [COMP_W-1:0] comp,
                                        logic [TIME_W-1:0] started, end_us, now_ms,
                                        bit fixed = 1'b0,
                                        timing_outcome_t o = '0);
        timing_cmd_t c;
        c.op      = op;
        c.comp    = comp;
        c.started = started;
        c.end_us  = end_us;
        c.now_ms  = now_ms;
        c.fixed   = fixed;
        c.outcome = o;
        return c;
    endfunction

    // Random command. Durations cluster around the threshold, components
    // cluster on a few hot entries so forwarding and pacing get exercised,
    // and the millisecond clock mostly creeps forward with some jumps.
    function automatic timing_cmd_t random_cmd();
        timing_cmd_t       c;
        logic [TIME_W-1:0] dur;
        int                sel;
        c.fixed   = 1'b0;
        c.outcome = '0;
        c.op      = ($urandom_range(0, 99) < 70) ? OP_RECORD : OP_READ;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            c.comp = $urandom_range(NCOMP, 15);
        else if (sel < 5)
            c.comp = $urandom_range(0, 2);
        else
            c.comp = $urandom_range(0, NCOMP - 1);
        case ($urandom_range(0, 5))
            0:       dur = model_thr + $urandom_range(0, 2) - 1;
            1:       dur = $urandom;
            2:       dur = $urandom_range(0, 1000);
            3:       dur = model_thr + $urandom_range(1, 100000);
            4:       dur = model_thr - $urandom_range(1, 100000);
            default: dur = $urandom_range(0, 1) ? '1 : '0;
        endcase
        c.started = $urandom;
        c.end_us  = c.started + dur;
        sel = $urandom_range(0, 9);
        if (sel >= 1 && sel <= 5)
            ms_clock = ms_clock + $urandom_range(0, 20);
        else if (sel == 6 || sel == 7)
            ms_clock = ms_clock + model_ivl + $urandom_range(0, 2) - 1;
        else if (sel == 8)
            ms_clock = $urandom;
        c.now_ms = (sel == 9) ? '0 : ms_clock;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // ------------------------------------------------------------------
    // Monitor: compare each response transfer with the oldest expectation,
    // then run the model on the command transfer of the same edge. A
    // command's response can never appear on its own acceptance edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        timing_outcome_t got, want, fresh;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.bad                = rsp_ch.bad_component;
                got.res.should_alert   = rsp_ch.should_alert;
                got.res.run_us         = rsp_ch.run_us;
                got.res.latest_us      = rsp_ch.latest_us;
                got.res.peak_us        = rsp_ch.peak_us;
                got.res.slow_total     = rsp_ch.slow_total;
                got.res.latest_slow_us = rsp_ch.latest_slow_us;
                got.res.slow_age_ms    = rsp_ch.slow_age_ms;
                if (got.res.should_alert === 1'b1)
                    n_alert++;
                if (pending_outcomes.size() == 0)
                    report_mismatch("response transfer with no command outstanding");
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("bad_component",  want.bad,                got.bad);
                    check_field("should_alert",   want.res.should_alert,   got.res.should_alert);
                    check_field("run_us",         want.res.run_us,         got.res.run_us);
                    check_field("latest_us",      want.res.latest_us,      got.res.latest_us);
                    check_field("peak_us",        want.res.peak_us,        got.res.peak_us);
                    check_field("slow_total",     want.res.slow_total,     got.res.slow_total);
                    check_field("latest_slow_us", want.res.latest_slow_us, got.res.latest_slow_us);
                    check_field("slow_age_ms",    want.res.slow_age_ms,    got.res.slow_age_ms);
                end
            end
            if (cmd_ch.valid && !cmd_ch.ready)
                n_cmd_stall++;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                fresh = predict_timing(ctm_op_t'(cmd_ch.opcode), cmd_ch.component,
                                       cmd_ch.started_us, cmd_ch.now_us, cmd_ch.now_ms);
                // table rows with a typed-in answer are checked against that
                if (cur_cmd.fixed)
                    fresh = cur_cmd.outcome;
                pending_outcomes.push_back(fresh);
                if (cmd_ch.component >= NCOMP)
                    n_bad++;
                else if (ctm_op_t'(cmd_ch.opcode) == OP_RECORD)
                    n_record++;
                else
                    n_read++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver: bursts of random length with random gaps. valid is
    // only touched once per falling edge.
    // ------------------------------------------------------------------
    task automatic offer(timing_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cur_cmd = c;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= c.op;
        cmd_ch.component  <= c.comp;
        cmd_ch.started_us <= c.started;
        cmd_ch.now_us     <= c.end_us;
        cmd_ch.now_ms     <= c.now_ms;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait for every response to come back.
    task automatic drain_responses();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // Registers are only written with nothing in flight.
    task automatic apply_config(logic [TIME_W-1:0] thr, logic [TIME_W-1:0] ivl);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SLOW_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge clk);
        cfg_index <= REG_ALERT_INTERVAL;
        cfg_wdata <= ivl;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_thr = thr;
        model_ivl = ivl;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random ready patterns in segments, plus a long
    // hold-off on request while the driver keeps pushing.
    // ------------------------------------------------------------------
    initial
    begin : response_sink
        int mode, seg, tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            repeat (seg)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                tick++;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;                          // no stalls
                    1:       rsp_ch.ready <= $urandom_range(0, 1);          // coin flip
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: rsp_ch.ready <= (tick % 4 != 0);               // periodic bubble
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (cmd_ch.valid && cmd_ch.ready)
                || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, pending_outcomes.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        timing_outcome_t all_zero, bad_only;

        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_SLOW_THRESHOLD;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_RECORD;
        cmd_ch.component  = '0;
        cmd_ch.started_us = '0;
        cmd_ch.now_us     = '0;
        cmd_ch.now_ms     = '0;
        rsp_ch.ready      = 1'b0;

        // model starts from the reset state
        model_thr = SLOW_THRESHOLD_RST;
        model_ivl = ALERT_INTERVAL_RST;
        for (int i = 0; i < NCOMP; i++)
            model_tab[i] = '0;
        cur_cmd = row(OP_RECORD, 0, 0, 0, 0);

        all_zero = outcome(0, 0, 0, 0, 0, 0, 0, 0);
        bad_only = outcome(1, 0, 0, 0, 0, 0, 0, 0);

        // Directed table, run under the reset register values.
        // Fresh entries read back as all zero.
        directed_rows.push_back(row(OP_READ,   0,  0, 0, 5, 1, all_zero));
        directed_rows.push_back(row(OP_READ,   12, '1, 0, '1, 1, all_zero));
        // Out-of-range components, both operations, extreme field values.
        directed_rows.push_back(row(OP_RECORD, 13, 0, 100, 7, 1, bad_only));
        directed_rows.push_back(row(OP_READ,   15, '1, '1, '1, 1, bad_only));
        directed_rows.push_back(row(OP_RECORD, 14, '1, 0, 0, 1, bad_only));
        // Exactly at threshold is not slow; one above is, and alerts first time.
        directed_rows.push_back(row(OP_RECORD, 0, 0, 50000, 100, 1,
                                    outcome(0, 0, 50000, 50000, 50000, 0, 0, 0)));
        directed_rows.push_back(row(OP_RECORD, 0, 0, 50001, 200, 1,
                                    outcome(0, 1, 50001, 50001, 50001, 1, 50001, 0)));
        // Pacing: inside the interval no alert, one short of it none,
        // exactly at it alerts again.
        directed_rows.push_back(row(OP_RECORD, 0, 100, 60100, 5000));
        directed_rows.push_back(row(OP_READ,   0, 0, 0, 7000));
        directed_rows.push_back(row(OP_RECORD, 0, 0, 70000, 10199));
        directed_rows.push_back(row(OP_RECORD, 0, 0, 70000, 10200));
        // Microsecond wrap, then a slow run stamped at millisecond zero:
        // it reads as never slow and never alerted afterwards.
        directed_rows.push_back(row(OP_RECORD, 1, 32'hFFFF_FFF0, 32'h10, 3));
        directed_rows.push_back(row(OP_RECORD, 1, 32'h10, 0, 0));
        directed_rows.push_back(row(OP_READ,   1, 0, 0, 500));
        directed_rows.push_back(row(OP_RECORD, 1, 0, 60000, 1));
        // Largest duration, millisecond wrap on the age, peak holds.
        directed_rows.push_back(row(OP_RECORD, 2, 0, '1, '1));
        directed_rows.push_back(row(OP_READ,   2, 0, 0, 0));
        directed_rows.push_back(row(OP_RECORD, 2, 0, 10, 4));
        directed_rows.push_back(row(OP_RECORD, 3, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 9));
        // Same entry several times in a row (forwarding path).
        directed_rows.push_back(row(OP_RECORD, 4, 0, 100000, 300));
        directed_rows.push_back(row(OP_RECORD, 4, 0, 200000, 301));
        directed_rows.push_back(row(OP_READ,   4, 0, 0, 302));
        // Last valid entry with alternating bit patterns.
        directed_rows.push_back(row(OP_RECORD, 12, 32'hAAAA_AAAA,
                                    32'hAAAA_AAAA + 32'd60000, 32'h5555_5555));
        directed_rows.push_back(row(OP_READ,   12, 0, 0, 32'h5555_5556));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Random phases; the first keeps reset values, the rest hit the
        // register extremes and a couple of ordinary settings.
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain_responses();
                case (p)
                    1:       apply_config('0, '0);
                    2:       apply_config('1, '1);
                    3:       apply_config(32'd1000, 32'd1);
                    default: apply_config($urandom_range(20000, 80000),
                                          $urandom_range(100, 20000));
                endcase
            end
            // back-pressure: response side holds off while a long burst
            // keeps coming, so the pipe fills and the command side stalls
            hold_req   = 1'b1;
            burst_left = 40;
            repeat (RANDOM_ITEMS / N_PHASES)
                offer(random_cmd());
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));

        $display("Run covered %0d records, %0d reads, %0d out-of-range commands, %0d alerts",
                 n_record, n_read, n_bad, n_alert);
        $display("under %0d register settings, with %0d command stall cycles; %0d mismatches",
                 n_settings + 1, n_cmd_stall, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
